[sv/mfk_pkg.sv]
package mfk_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_LOCK   = 3'd0;
  localparam logic [2:0] REG_RADIUS = 3'd1;
  localparam logic [2:0] REG_TRACK  = 3'd2;
  localparam logic [2:0] REG_BASE   = 3'd3;
  localparam logic [2:0] REG_OFFX   = 3'd4;
  localparam logic [2:0] REG_OFFY   = 3'd5;

  // 1800/pi in Q16; also half of the forward gain 7200/pi * 2^15
  localparam logic [25:0] K_MIX = 26'd37549362;
  localparam logic [26:0] K_FWD = 27'd75098724;

  // quarter sine polynomial, Q15
  localparam logic [15:0] SIN_C1  = 16'd51472;
  localparam logic [14:0] SIN_C3  = 15'd21024;
  localparam logic [11:0] SIN_C5  = 12'd2320;
  localparam logic [14:0] Q15_RND = 15'd16384;
  localparam logic [14:0] Q15_MAX = 15'd32767;

endpackage

[sv/mecanum_field_kinematics.sv]
// Each start beat that is taken gives one result, strobed on done.
// Throughput: one item per cycle; busy stays low and the block never stalls.
// The depth is set by the quotient rows: one cell per result bit (17 for the
// wheel targets), fed by the sine, rotate and multiply stages.
// Reset (rst, synchronous, active high) clears the pipeline valids and loads
// the register defaults; the receiver cannot stall the done strobe.
module mecanum_field_kinematics import mfk_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [13:0]     target_vx,
  input  logic signed [13:0]     target_vy,
  input  logic signed [12:0]     target_wz,
  input  logic [ANGLE_BITS-1:0]  heading,
  input  logic signed [16:0]     meas_front_left,
  input  logic signed [16:0]     meas_front_right,
  input  logic signed [16:0]     meas_back_left,
  input  logic signed [16:0]     meas_back_right,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [12:0]            cfg_data,
  output logic                   done,
  output logic signed [16:0]     drive_front_left,
  output logic signed [16:0]     drive_front_right,
  output logic signed [16:0]     drive_back_left,
  output logic signed [16:0]     drive_back_right,
  output logic signed [13:0]     est_vx,
  output logic signed [13:0]     est_vy,
  output logic signed [12:0]     est_wz
);

  localparam int LAT = 32;
  localparam int FW  = ANGLE_BITS - 2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // round-to-nearest quotient magnitude + sign -> saturated signed value
  function automatic logic signed [16:0] sat_quo(input logic [16:0] q,
                                                 input logic neg,
                                                 input int unsigned w);
    logic [16:0]        lim;
    logic signed [16:0] res;
    lim = 17'd1 << (w - 1);
    if (q >= lim) res = neg ? -$signed(lim) : $signed(lim - 17'd1);
    else          res = neg ? -$signed(q) : $signed(q);
    return res;
  endfunction

  // always accepting; never back-pressures either port
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic               lock;
  logic [11:0]        radius;
  logic [12:0]        track, base;
  logic signed [12:0] offx, offy;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock   <= 1'b0;
      radius <= 12'd763;
      track  <= 13'd2000;
      base   <= 13'd1900;
      offx   <= '0;
      offy   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOCK:   lock   <= cfg_data[0];
        REG_RADIUS: radius <= cfg_data[11:0];
        REG_TRACK:  track  <= cfg_data;
        REG_BASE:   base   <= cfg_data;
        REG_OFFX:   offx   <= $signed(cfg_data);
        REG_OFFY:   offy   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // derived constants, registered from the configuration registers; an item
  // taken close to a write can still use old values in some stages
  logic [11:0]        r_eff;
  logic [13:0]        l_sum, ld_eff;
  logic [40:0]        d_fwd;
  logic [39:0]        h_fwd;
  logic signed [15:0] geo [4];
  logic signed [15:0] xs, ys, ls;

  always_comb begin
    xs = 16'(offx);
    ys = 16'(offy);
    ls = $signed({2'b00, l_sum});
  end

  always_ff @(posedge clk) begin
    r_eff  <= (radius == 12'd0) ? 12'd1 : radius;
    l_sum  <= 14'(track) + 14'(base);
    ld_eff <= (l_sum == 14'd0) ? 14'd1 : l_sum;
    d_fwd  <= 41'(ld_eff) * 41'(K_FWD);
    h_fwd  <= 40'(ld_eff) * 40'(K_MIX);
    geo[0] <= ys + xs - ls;
    geo[1] <= -ys + xs - ls;
    geo[2] <= ys - xs - ls;
    geo[3] <= -ys - xs - ls;
  end

  // ---------------------------------------------------------------------
  // stage valids and input capture (stage 1)
  // ---------------------------------------------------------------------
  logic [LAT-1:1] vld;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[LAT-2:1], start & ~busy};
  end

  logic signed [13:0]    vx_d [1:6];
  logic signed [13:0]    vy_d [1:6];
  logic signed [12:0]    wz_d [1:9];
  logic [ANGLE_BITS-1:0] hd1;
  logic signed [16:0]    fl1, fr1, bl1, br1;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      vx_d[1] <= target_vx;
      vy_d[1] <= target_vy;
      wz_d[1] <= target_wz;
      hd1     <= heading;
      fl1     <= meas_front_left;
      fr1     <= meas_front_right;
      bl1     <= meas_back_left;
      br1     <= meas_back_right;
    end
    for (int i = 2; i <= 6; i++) begin
      vx_d[i] <= vx_d[i-1];
      vy_d[i] <= vy_d[i-1];
    end
    for (int i = 2; i <= 9; i++) wz_d[i] <= wz_d[i-1];
  end

  // ---------------------------------------------------------------------
  // sine / cosine, stages 2..6
  // ---------------------------------------------------------------------
  logic [FW+14:0]     zfull;
  logic [15:0]        z_sin, z_cos;
  logic [14:0]        ps5, pc5;
  logic [1:0]         quad_d [2:5];
  logic signed [15:0] sn6, cs6;

  always_comb begin
    zfull     = {hd1[FW-1:0], 15'd0} >> FW;
    z_sin     = zfull[15:0];
    z_cos     = 16'(17'd32768 - 17'(z_sin));
  end

  mfk_qsine u_sin (.clk(clk), .z(z_sin), .s(ps5));
  mfk_qsine u_cos (.clk(clk), .z(z_cos), .s(pc5));

  always_ff @(posedge clk) begin
    quad_d[2] <= hd1[ANGLE_BITS-1:ANGLE_BITS-2];
    for (int i = 3; i <= 5; i++) quad_d[i] <= quad_d[i-1];
    unique case (quad_d[5])
      QUAD_0: begin sn6 <=  $signed({1'b0, ps5}); cs6 <=  $signed({1'b0, pc5}); end
      QUAD_1: begin sn6 <=  $signed({1'b0, pc5}); cs6 <= -$signed({1'b0, ps5}); end
      QUAD_2: begin sn6 <= -$signed({1'b0, ps5}); cs6 <= -$signed({1'b0, pc5}); end
      QUAD_3: begin sn6 <= -$signed({1'b0, pc5}); cs6 <=  $signed({1'b0, ps5}); end
      default: begin sn6 <= '0; cs6 <= '0; end
    endcase
  end

  // ---------------------------------------------------------------------
  // wheel mix, stages 7..13
  // ---------------------------------------------------------------------
  logic signed [29:0] pvc7, pvs7, pyc7, pxs7;
  logic signed [30:0] p8, q8;
  logic signed [31:0] cmb9 [4];
  logic signed [59:0] mk10 [4];
  logic signed [28:0] wg10 [4];
  logic signed [60:0] n11  [4];
  logic [59:0]        mag12 [4];
  logic               neg12 [4];
  logic [30:0]        num13 [4];
  logic               neg13 [4];
  logic [59:0]        nabs  [4];

  always_comb begin
    for (int j = 0; j < 4; j++) nabs[j] = n11[j][60] ? 60'(-n11[j]) : 60'(n11[j]);
  end

  always_ff @(posedge clk) begin
    pvc7 <= 30'(vx_d[6]) * 30'(cs6);
    pvs7 <= 30'(vy_d[6]) * 30'(sn6);
    pyc7 <= 30'(vy_d[6]) * 30'(cs6);
    pxs7 <= 30'(vx_d[6]) * 30'(sn6);
    p8   <= 31'(pvc7) + 31'(pvs7);
    q8   <= 31'(pyc7) - 31'(pxs7);
    cmb9[0] <= 32'(p8) - 32'(q8);
    cmb9[1] <= -32'(p8) - 32'(q8);
    cmb9[2] <= 32'(p8) + 32'(q8);
    cmb9[3] <= -32'(p8) + 32'(q8);
    for (int j = 0; j < 4; j++) begin
      mk10[j]  <= 60'(cmb9[j]) * 60'($signed({1'b0, K_MIX}));
      wg10[j]  <= 29'(wz_d[9]) * 29'(geo[j]);
      n11[j]   <= 61'(mk10[j]) + 61'($signed({wg10[j], 31'd0}));
      neg12[j] <= n11[j][60];
      mag12[j] <= nabs[j];
      // d = 2^31 R: fold the low 30 bits away, divide by 2R
      num13[j] <= {1'b0, mag12[j][59:30]} + 31'(r_eff);
      neg13[j] <= neg12[j];
    end
  end

  logic [16:0] wq  [4];
  logic        wng [4];

  for (genvar j = 0; j < 4; j++) begin : g_wheel
    mfk_div_row #(.NW(31), .DW(13), .W(17), .PAD(1)) u_row (
      .clk     (clk),
      .num     (num13[j]),
      .den     ({r_eff, 1'b0}),
      .neg_in  (neg13[j]),
      .quo     (wq[j]),
      .neg_out (wng[j])
    );
  end

  // ---------------------------------------------------------------------
  // forward kinematics, stages 2..11
  // ---------------------------------------------------------------------
  logic signed [18:0] a2, b2, s2;
  logic signed [33:0] al3, bl3;
  logic signed [31:0] sy3, sx3;
  logic [18:0]        sabs3;
  logic               wneg3, wneg4, wneg5;
  logic [30:0]        wp4;
  logic [31:0]        wn5;
  logic signed [34:0] u_d [4:6];
  logic signed [34:0] v_d [4:6];
  logic signed [50:0] uc7, vs7, us7, vc7;
  logic signed [51:0] e1_8, e2_8;
  logic [51:0]        e1abs, e2abs;
  logic [49:0]        m1_9, m2_9;
  logic               n1_9, n2_9, n1_10, n2_10, n1_11, n2_11;
  logic [61:0]        f1_10, f2_10;
  logic [62:0]        f1_11, f2_11;
  logic signed [18:0] fl19, fr19, bl19, br19;

  always_comb begin
    fl19  = 19'(fl1);
    fr19  = 19'(fr1);
    bl19  = 19'(bl1);
    br19  = 19'(br1);
    e1abs = e1_8[51] ? 52'(-e1_8) : 52'(e1_8);
    e2abs = e2_8[51] ? 52'(-e2_8) : 52'(e2_8);
  end

  always_ff @(posedge clk) begin
    a2 <= fl19 - fr19 + bl19 - br19;
    b2 <= -fl19 - fr19 + bl19 + br19;
    s2 <= fl19 + fr19 + bl19 + br19;

    al3   <= 34'(a2) * 34'($signed({1'b0, ld_eff}));
    bl3   <= 34'(b2) * 34'($signed({1'b0, ld_eff}));
    sy3   <= 32'(s2) * 32'(offy);
    sx3   <= 32'(s2) * 32'(offx);
    // est_wz = -S R / 4L: negative when S is positive
    wneg3 <= !s2[18] && (s2 != 19'sd0);
    sabs3 <= s2[18] ? 19'(-s2) : 19'(s2);

    u_d[4] <= 35'(al3) + 35'(sy3);
    v_d[4] <= 35'(bl3) - 35'(sx3);
    wp4    <= 31'(sabs3) * 31'(r_eff);
    wneg4  <= wneg3;

    wn5    <= 32'(wp4) + 32'({ld_eff, 1'b0});
    wneg5  <= wneg4;

    for (int i = 5; i <= 6; i++) begin
      u_d[i] <= u_d[i-1];
      v_d[i] <= v_d[i-1];
    end

    uc7 <= 51'(u_d[6]) * 51'(cs6);
    vs7 <= 51'(v_d[6]) * 51'(sn6);
    us7 <= 51'(u_d[6]) * 51'(sn6);
    vc7 <= 51'(v_d[6]) * 51'(cs6);

    e1_8 <= 52'(uc7) - 52'(vs7);
    e2_8 <= 52'(us7) + 52'(vc7);

    n1_9 <= e1_8[51];
    n2_9 <= e2_8[51];
    m1_9 <= e1abs[49:0];
    m2_9 <= e2abs[49:0];

    f1_10 <= 62'(m1_9) * 62'(r_eff);
    f2_10 <= 62'(m2_9) * 62'(r_eff);
    n1_10 <= n1_9;
    n2_10 <= n2_9;

    f1_11 <= 63'(f1_10) + 63'(h_fwd);
    f2_11 <= 63'(f2_10) + 63'(h_fwd);
    n1_11 <= n1_10;
    n2_11 <= n2_10;
  end

  logic [13:0] xq, yq;
  logic [12:0] zq;
  logic        xn, yn, zn;

  mfk_div_row #(.NW(63), .DW(41), .W(14), .PAD(6)) u_row_vx (
    .clk(clk), .num(f1_11), .den(d_fwd), .neg_in(n1_11), .quo(xq), .neg_out(xn)
  );

  mfk_div_row #(.NW(63), .DW(41), .W(14), .PAD(6)) u_row_vy (
    .clk(clk), .num(f2_11), .den(d_fwd), .neg_in(n2_11), .quo(yq), .neg_out(yn)
  );

  mfk_div_row #(.NW(32), .DW(16), .W(13), .PAD(13)) u_row_wz (
    .clk(clk), .num(wn5), .den({ld_eff, 2'b00}), .neg_in(wneg5), .quo(zq), .neg_out(zn)
  );

  // ---------------------------------------------------------------------
  // output registers (stage 32)
  // ---------------------------------------------------------------------
  logic signed [16:0] dv [4];
  logic signed [16:0] xv, yv, zv;

  always_comb begin
    for (int j = 0; j < 4; j++) dv[j] = lock ? 17'sd0 : sat_quo(wq[j], wng[j], 17);
    xv = sat_quo(17'(xq), xn, 14);
    yv = sat_quo(17'(yq), yn, 14);
    zv = sat_quo(17'(zq), zn, 13);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[LAT-1];
  end

  always_ff @(posedge clk) begin
    drive_front_left  <= dv[0];
    drive_front_right <= dv[1];
    drive_back_left   <= dv[2];
    drive_back_right  <= dv[3];
    est_vx            <= xv[13:0];
    est_vy            <= yv[13:0];
    est_wz            <= zv[12:0];
  end

endmodule

[sv/mfk_qsine.sv]
module mfk_qsine import mfk_pkg::*; (
  input  logic        clk,
  input  logic [15:0] z,
  output logic [14:0] s
);

  // four registered steps, one product each
  logic [15:0] z_a, z_b, z_c;
  logic [15:0] z2_a, z2_b;
  logic [14:0] t1_b;
  logic [15:0] t2_c;

  logic [30:0] zz;
  logic [26:0] m1;
  logic [29:0] m2;
  logic [30:0] m3;
  logic [15:0] r3;

  always_comb begin
    zz = 31'(z) * 31'(z);
    m1 = 27'(z2_a) * 27'(SIN_C5);
    m2 = 30'(z2_b) * 30'(t1_b);
    m3 = 31'(z_c) * 31'(t2_c);
    r3 = 16'((m3 + 31'(Q15_RND)) >> 15);
  end

  always_ff @(posedge clk) begin
    z_a  <= z;
    z2_a <= 16'((zz + 31'(Q15_RND)) >> 15);
    z_b  <= z_a;
    z2_b <= z2_a;
    t1_b <= SIN_C3 - 15'((m1 + 27'(Q15_RND)) >> 15);
    z_c  <= z_b;
    t2_c <= SIN_C1 - 16'((m2 + 30'(Q15_RND)) >> 15);
    s    <= (r3 > 16'(Q15_MAX)) ? Q15_MAX : r3[14:0];
  end

endmodule

[sv/mfk_div_cell.sv]
module mfk_div_cell #(
  parameter int NW = 31,
  parameter int DW = 13,
  parameter int W  = 17,
  parameter int SH = 0
) (
  input  logic          clk,
  input  logic [NW-1:0] rem_in,
  input  logic [W-1:0]  quo_in,
  input  logic          neg_in,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] rem_out,
  output logic [W-1:0]  quo_out,
  output logic          neg_out
);

  localparam int CW = NW + DW + SH;

  logic [CW-1:0] dsh;
  logic          ge;

  always_comb begin
    dsh = CW'(den) << SH;
    ge  = CW'(rem_in) >= dsh;
  end

  // one quotient bit per cell
  always_ff @(posedge clk) begin
    rem_out <= ge ? (rem_in - dsh[NW-1:0]) : rem_in;
    quo_out <= {quo_in[W-2:0], ge};
    neg_out <= neg_in;
  end

endmodule

[sv/mfk_div_row.sv]
module mfk_div_row #(
  parameter int NW  = 31,
  parameter int DW  = 13,
  parameter int W   = 17,
  parameter int PAD = 1
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          neg_in,
  output logic [W-1:0]  quo,
  output logic          neg_out
);

  logic [NW-1:0] rem [W+1];
  logic [W-1:0]  qv  [W+1];
  logic          ng  [W+1];

  assign rem[0] = num;
  assign qv[0]  = '0;
  assign ng[0]  = neg_in;

  for (genvar i = 0; i < W; i++) begin : g_cell
    mfk_div_cell #(.NW(NW), .DW(DW), .W(W), .SH(W - 1 - i)) u_cell (
      .clk     (clk),
      .rem_in  (rem[i]),
      .quo_in  (qv[i]),
      .neg_in  (ng[i]),
      .den     (den),
      .rem_out (rem[i+1]),
      .quo_out (qv[i+1]),
      .neg_out (ng[i+1])
    );
  end

  // alignment stages so all rows finish together
  if (PAD == 0) begin : g_nopad
    assign quo     = qv[W];
    assign neg_out = ng[W];
  end else begin : g_pad
    logic [W-1:0] pq [PAD];
    logic         pn [PAD];
    always_ff @(posedge clk) begin
      pq[0] <= qv[W];
      pn[0] <= ng[W];
      for (int k = 1; k < PAD; k++) begin
        pq[k] <= pq[k-1];
        pn[k] <= pn[k-1];
      end
    end
    assign quo     = pq[PAD-1];
    assign neg_out = pn[PAD-1];
  end

endmodule

[sv/mfk_checker.sv]
module mfk_checker import mfk_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [12:0]        cfg_data,
  input logic signed [16:0] meas_front_left,
  input logic signed [16:0] meas_front_right,
  input logic signed [16:0] meas_back_left,
  input logic signed [16:0] meas_back_right,
  input logic signed [16:0] drive_front_left,
  input logic signed [16:0] drive_front_right,
  input logic signed [16:0] drive_back_left,
  input logic signed [16:0] drive_back_right,
  input logic signed [13:0] est_vx,
  input logic signed [13:0] est_vy,
  input logic signed [12:0] est_wz
);

  logic lock_sh;

  always_ff @(posedge clk) begin
    if (rst) lock_sh <= 1'b0;
    else if (cfg_valid && cfg_ready && cfg_index == REG_LOCK) lock_sh <= cfg_data[0];
  end

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 32))
    else $error("result beat without matching start");

  a_lock_zero: assert property (@(posedge clk) disable iff (rst)
    (done && lock_sh) |-> (drive_front_left == 17'sd0 && drive_front_right == 17'sd0 &&
                           drive_back_left == 17'sd0 && drive_back_right == 17'sd0))
    else $error("wheels locked but drive nonzero");

  a_still_est: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && meas_front_left == 17'sd0 &&
                   meas_front_right == 17'sd0 && meas_back_left == 17'sd0 &&
                   meas_back_right == 17'sd0, 32))
    |-> (est_vx == 14'sd0 && est_vy == 14'sd0 && est_wz == 13'sd0))
    else $error("still wheels gave nonzero estimate");

endmodule

bind mecanum_field_kinematics mfk_checker u_chk (.*);

[dv/tb.sv]
`timescale 1ns / 100ps

// Checks the mecanum kinematics pipeline against an in-bench integer predictor.
// A directed table comes first, then random beats under several register settings.
module tb;
  import mfk_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [13:0] target_vx = '0;
  logic signed [13:0] target_vy = '0;
  logic signed [12:0] target_wz = '0;
  logic [15:0] heading = '0;
  logic signed [16:0] meas_front_left = '0;
  logic signed [16:0] meas_front_right = '0;
  logic signed [16:0] meas_back_left = '0;
  logic signed [16:0] meas_back_right = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic done;
  logic signed [16:0] drive_front_left, drive_front_right, drive_back_left, drive_back_right;
  logic signed [13:0] est_vx, est_vy;
  logic signed [12:0] est_wz;

  mecanum_field_kinematics u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // one input beat
  typedef struct {
    logic signed [13:0] vx, vy;
    logic signed [12:0] wz;
    logic [15:0] hd;
    logic signed [16:0] fl, fr, bl, br;
  } sample_t;

  // one result beat
  typedef struct {
    logic signed [16:0] dfl, dfr, dbl, dbr;
    logic signed [13:0] evx, evy;
    logic signed [12:0] ewz;
  } motion_t;

  // directed row: beat plus an optional hand-typed answer
  typedef struct {
    sample_t s;
    bit typed;
    motion_t m;
  } vec_t;

  // shadow copy of the register file
  logic lock_q = 1'b0;
  logic [11:0] radius_q = 12'd763;
  logic [12:0] track_q = 13'd2000;
  logic [12:0] base_q = 13'd1900;
  logic [12:0] offx_q = '0;
  logic [12:0] offy_q = '0;

  motion_t motion_q[$];
  int errors = 0;

  function automatic longint rnd_div(longint n, longint d);
    longint m, q;
    m = n < 0 ? -n : n;
    q = (m + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint qsine(longint z);
    longint z2, t, s;
    z2 = (z * z + 16384) >>> 15;
    t = 21024 - ((z2 * 2320 + 16384) >>> 15);
    t = 51472 - ((z2 * t + 16384) >>> 15);
    s = (z * t + 16384) >>> 15;
    return s > 32767 ? 32767 : s;
  endfunction

  function automatic longint wheel_rate(longint comb, longint wz, longint geo, longint r);
    return rnd_div(comb * 37549362 + wz * geo * (64'sd1 <<< 31), r * (64'sd1 <<< 31));
  endfunction

  function automatic motion_t predict_motion(sample_t x);
    motion_t o;
    longint z, ps, pc, sn, cs, p, q, r, l, ld, xb, yb, a, b, sm, u, v;
    longint fl, fr, bl, br;
    z = longint'(x.hd[13:0]) << 1;
    ps = qsine(z);
    pc = qsine(32768 - z);
    case (x.hd[15:14])
      2'd0: begin sn = ps; cs = pc; end
      2'd1: begin sn = pc; cs = -ps; end
      2'd2: begin sn = -ps; cs = -pc; end
      default: begin sn = -pc; cs = ps; end
    endcase
    xb = longint'($signed(offx_q));
    yb = longint'($signed(offy_q));
    r = radius_q == 0 ? 1 : longint'(radius_q);
    l = longint'(track_q) + longint'(base_q);
    ld = l == 0 ? 1 : l;
    p = x.vx * cs + x.vy * sn;
    q = x.vy * cs - x.vx * sn;
    if (lock_q) begin
      o.dfl = '0; o.dfr = '0; o.dbl = '0; o.dbr = '0;
    end else begin
      o.dfl = 17'(clamp(wheel_rate(p - q, x.wz, yb + xb - l, r), 17));
      o.dfr = 17'(clamp(wheel_rate(-p - q, x.wz, -yb + xb - l, r), 17));
      o.dbl = 17'(clamp(wheel_rate(p + q, x.wz, yb - xb - l, r), 17));
      o.dbr = 17'(clamp(wheel_rate(-p + q, x.wz, -yb - xb - l, r), 17));
    end
    fl = longint'(x.fl); fr = longint'(x.fr); bl = longint'(x.bl); br = longint'(x.br);
    a = fl - fr + bl - br;
    b = -fl - fr + bl + br;
    sm = fl + fr + bl + br;
    u = a * ld + sm * yb;
    v = b * ld - sm * xb;
    o.evx = 14'(clamp(rnd_div((u * cs - v * sn) * r, ld * 75098724), 14));
    o.evy = 14'(clamp(rnd_div((u * sn + v * cs) * r, ld * 75098724), 14));
    o.ewz = 13'(clamp(rnd_div(-sm * r, 4 * ld), 13));
    return o;
  endfunction

  function automatic sample_t rand_sample();
    sample_t x;
    x.vx = 14'($urandom); x.vy = 14'($urandom); x.wz = 13'($urandom);
    x.hd = 16'($urandom);
    x.fl = 17'($urandom); x.fr = 17'($urandom); x.bl = 17'($urandom);
    x.br = 17'($urandom);
    // mostly realistic speeds so the saturation does not hide the math
    if ($urandom_range(3) != 0) begin
      x.vx = $signed(14'($urandom_range(4000))) - 14'sd2000;
      x.vy = $signed(14'($urandom_range(4000))) - 14'sd2000;
      x.wz = $signed(13'($urandom_range(720))) - 13'sd360;
      x.fl = $signed(17'($urandom_range(8000))) - 17'sd4000;
      x.fr = $signed(17'($urandom_range(8000))) - 17'sd4000;
      x.bl = $signed(17'($urandom_range(8000))) - 17'sd4000;
      x.br = $signed(17'($urandom_range(8000))) - 17'sd4000;
    end
    return x;
  endfunction

  // raises valid and holds it; the caller drops it after the last write
  task automatic cfg_write(logic [2:0] idx, logic [12:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOCK: lock_q = val[0];
      REG_RADIUS: radius_q = val[11:0];
      REG_TRACK: track_q = val;
      REG_BASE: base_q = val;
      REG_OFFX: offx_q = val;
      default: offy_q = val;
    endcase
  endtask

  // waits out every outstanding beat plus the pipeline depth
  task automatic drain();
    while (motion_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // start stays up across back-to-back beats and drops only for a gap
  task automatic send_sample(sample_t x, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    target_vx <= x.vx; target_vy <= x.vy; target_wz <= x.wz; heading <= x.hd;
    meas_front_left <= x.fl; meas_front_right <= x.fr;
    meas_back_left <= x.bl; meas_back_right <= x.br;
    do @(posedge clk); while (busy);
    motion_q.push_back(predict_motion(x));
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  // result side: compare each done beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (motion_q.size() == 0) begin
        $error("result beat with no prediction pending");
        errors++;
      end else begin
        motion_t m;
        m = motion_q.pop_front();
        if (drive_front_left !== m.dfl) begin
          $error("drive_front_left exp %0d got %0d", m.dfl, drive_front_left); errors++;
        end
        if (drive_front_right !== m.dfr) begin
          $error("drive_front_right exp %0d got %0d", m.dfr, drive_front_right); errors++;
        end
        if (drive_back_left !== m.dbl) begin
          $error("drive_back_left exp %0d got %0d", m.dbl, drive_back_left); errors++;
        end
        if (drive_back_right !== m.dbr) begin
          $error("drive_back_right exp %0d got %0d", m.dbr, drive_back_right); errors++;
        end
        if (est_vx !== m.evx) begin
          $error("est_vx exp %0d got %0d", m.evx, est_vx); errors++;
        end
        if (est_vy !== m.evy) begin
          $error("est_vy exp %0d got %0d", m.evy, est_vy); errors++;
        end
        if (est_wz !== m.ewz) begin
          $error("est_wz exp %0d got %0d", m.ewz, est_wz); errors++;
        end
      end
    end
  end

  // register sets per phase: lock, radius, track, base, offx, offy
  logic [12:0] phase_regs[7][6] = '{
    '{13'd0, 13'd763, 13'd2000, 13'd1900, 13'd0, 13'd0},
    '{13'd1, 13'd4095, 13'd8191, 13'd8191, 13'h0FFF, 13'h1000},
    '{13'd0, 13'd1, 13'd0, 13'd0, 13'h1000, 13'h0FFF},
    '{13'd0, 13'd0, 13'd1, 13'd0, 13'h1FFF, 13'd1},
    '{13'd0, 13'd4095, 13'd8191, 13'd8191, 13'h0FFF, 13'h1000},
    '{13'd0, 13'd500, 13'd1500, 13'd1200, 13'h1F00, 13'h0123},
    '{13'd0, 13'd763, 13'd2000, 13'd1900, 13'd0, 13'd0}
  };

  initial begin
    vec_t dir[$];
    vec_t e;
    sample_t x;
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; all-zero motion gives all-zero results at reset settings
    e.typed = 1'b1;
    e.s = '{14'sd0, 14'sd0, 13'sd0, 16'd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0};
    e.m = '{17'sd0, 17'sd0, 17'sd0, 17'sd0, 14'sd0, 14'sd0, 13'sd0};
    dir.push_back(e);
    e.typed = 1'b0;
    // extremes of every field and each quadrant boundary of the heading
    e.s = '{14'sh1FFF, 14'sh2000, 13'sh0FFF, 16'h0000, 17'sh0FFFF, 17'sh10000,
            17'sh0FFFF, 17'sh10000};
    dir.push_back(e);
    for (int qd = 1; qd < 4; qd++) begin
      e.s.hd = 16'(qd << 14);
      dir.push_back(e);
    end
    e.s = '{14'sh2000, 14'sh1FFF, 13'sh1000, 16'hFFFF, 17'sh10000, 17'sh0FFFF,
            17'sh10000, 17'sh0FFFF};
    dir.push_back(e);
    foreach (phase_regs[i]) begin
      e.s = '{14'sd1000, -14'sd500, 13'sd90, 16'(i * 16'h2AAB), 17'sd1200, -17'sd800,
              17'sd300, -17'sd2000};
      dir.push_back(e);
    end
    foreach (dir[i]) begin
      send_sample(dir[i].s, pick_gap());
      if (dir[i].typed) begin
        motion_q.pop_back();
        motion_q.push_back(dir[i].m);
      end
    end
    start <= 1'b0;
    drain();

    // random phases, one per register set; lock phase also exercised
    for (int ph = 0; ph < 7; ph++) begin
      for (int k = 0; k < 6; k++) cfg_write(3'(k), phase_regs[ph][k]);
      cfg_valid <= 1'b0;
      n = (ph == 1) ? 100 : 200;
      for (int i = 0; i < n; i++) begin
        x = rand_sample();
        if (i % 50 == 7) x.hd = 16'(($urandom_range(3)) << 14);
        send_sample(x, pick_gap());
        if (i == 100) begin
          // hold off until the pipeline is empty
          start <= 1'b0;
          while (motion_q.size() != 0) @(posedge clk);
        end
      end
      start <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
